// File: rtl/lsil_pkg.sv
package lsil_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_LINES_DEF   = 1024;
  localparam int OFFSET_BITS_DEF = 20;

  // Width of the command selector carried on s_tuser
  localparam int CMD_W = 2;

  // Width of one text byte
  localparam int BYTE_W = 8;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Line terminators
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // Result flags, carried on m_tuser
  typedef struct packed {
    logic table_full;
    logic bad_offset;
  } res_flags_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

endpackage

// File: rtl/line_start_index_and_locate_unit.sv
// Append and clear take one transaction per cycle while s_tready is high, with no result.
// Locate: takes the transaction, then runs the binary-search probes, each one read
//   of the line table, then loads the result register.
// One query at a time: s_tready is low until its answer loads; a held answer delays that.
// rst is synchronous: it empties the table and the text and clears the overflow flag at once, with no sweep.
module line_start_index_and_locate_unit #(
  parameter int MAX_LINES   = lsil_pkg::MAX_LINES_DEF,
  parameter int OFFSET_BITS = lsil_pkg::OFFSET_BITS_DEF,
  localparam int AW         = $clog2(MAX_LINES),
  localparam int LCW        = $clog2(MAX_LINES + 1),
  localparam int S_DW       = ((lsil_pkg::BYTE_W + OFFSET_BITS + 7) / 8) * 8,
  localparam int M_DW       = ((AW + OFFSET_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // command stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [S_DW-1:0]               s_tdata,  // text_byte, query_offset
  input  logic [lsil_pkg::CMD_W-1:0]    s_tuser,  // command
  // locate results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [M_DW-1:0]               m_tdata,  // line_number, column
  output logic [1:0]                    m_tuser   // bad_offset, table_full
);

  localparam logic [OFFSET_BITS-1:0] MAX_TEXT = {OFFSET_BITS{1'b1}};

  // ---------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------
  lsil_pkg::cmd_t                  cmd;
  logic [lsil_pkg::BYTE_W-1:0]     in_byte;
  logic [OFFSET_BITS-1:0]          in_off;
  logic                            s_xact;

  assign cmd     = lsil_pkg::cmd_t'(s_tuser);
  assign in_byte = s_tdata[lsil_pkg::BYTE_W-1:0];
  assign in_off  = s_tdata[lsil_pkg::BYTE_W +: OFFSET_BITS];
  assign s_xact  = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Text state
  // ---------------------------------------------------------------------------
  logic [LCW-1:0]         line_count;   // valid table entries, entry zero implied
  logic [OFFSET_BITS-1:0] text_length;
  logic                   pending_cr;
  logic                   overflowed;
  logic [OFFSET_BITS-1:0] last_start;   // copy of the newest table entry

  // Line table. Entry zero is never written: every read of it is forced to 0.
  logic [OFFSET_BITS-1:0] line_table [MAX_LINES];
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [OFFSET_BITS-1:0] wr_data;
  logic [AW-1:0]          rd_addr;
  logic [OFFSET_BITS-1:0] rdata;

  // ---------------------------------------------------------------------------
  // Search sequencer state
  // ---------------------------------------------------------------------------
  lsil_pkg::state_t       state;
  logic [LCW-1:0]         lo;
  logic [LCW-1:0]         hi;
  logic [LCW-1:0]         mid;
  logic [OFFSET_BITS-1:0] best_start;   // start of the last probe at or below q_off
  logic [OFFSET_BITS-1:0] q_off;
  logic                   q_bad;

  // result register
  logic [AW-1:0]          line_number;
  logic [OFFSET_BITS-1:0] column;
  lsil_pkg::res_flags_t   flags;

  assign s_tready = (state == lsil_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // Append decode
  // ---------------------------------------------------------------------------
  logic                   do_append;
  logic [OFFSET_BITS-1:0] next_pos;
  logic                   room;
  logic                   is_cr;
  logic                   is_lf;
  logic                   lf_fold;      // LF right after a recorded CR start
  logic                   add_start;

  assign do_append = s_xact && (cmd == lsil_pkg::CMD_APPEND) && (text_length != MAX_TEXT);
  assign next_pos  = text_length + OFFSET_BITS'(1);
  assign room      = (line_count < LCW'(MAX_LINES));
  assign is_cr     = (in_byte == lsil_pkg::CHAR_CR);
  assign is_lf     = (in_byte == lsil_pkg::CHAR_LF);
  assign lf_fold   = is_lf && pending_cr && (last_start == text_length);
  assign add_start = is_cr || (is_lf && !pending_cr);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = line_count[AW-1:0];
    wr_data = next_pos;
    if (do_append) begin
      if (add_start && room) begin
        wr_en = 1'b1;
      end else if (lf_fold) begin
        // move the CR's tentative start past the LF
        wr_en   = 1'b1;
        wr_addr = AW'(line_count - LCW'(1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Binary search step: one compare and one table read per cycle
  // ---------------------------------------------------------------------------
  logic [OFFSET_BITS-1:0] probe;
  logic                   le;
  logic [LCW-1:0]         lo_next;
  logic [LCW-1:0]         hi_next;
  logic [LCW-1:0]         mid_next;
  logic [LCW-1:0]         mid_first;
  logic                   searching;
  logic                   done;
  logic                   out_free;

  assign probe     = (mid == '0) ? '0 : rdata;
  assign le        = (probe <= q_off);
  assign lo_next   = le ? (mid + LCW'(1)) : lo;
  assign hi_next   = le ? hi : mid;
  assign mid_next  = lo_next + ((hi_next - lo_next) >> 1);
  assign mid_first = line_count >> 1;
  assign searching = (lo < hi);
  assign out_free  = !m_tvalid || m_tready;
  assign done      = (state == lsil_pkg::ST_SEARCH) && !searching && out_free;

  always_comb begin
    rd_addr = mid_first[AW-1:0];
    if (state == lsil_pkg::ST_SEARCH) begin
      rd_addr = mid_next[AW-1:0];
    end
  end

  // table port: one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_table[wr_addr] <= wr_data;
    end
    rdata <= line_table[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Text state update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || (s_xact && (cmd == lsil_pkg::CMD_CLEAR))) begin
      line_count  <= LCW'(1);
      text_length <= '0;
      pending_cr  <= 1'b0;
      overflowed  <= 1'b0;
      last_start  <= '0;
    end else if (do_append) begin
      text_length <= next_pos;
      pending_cr  <= is_cr;
      if (add_start) begin
        if (room) begin
          line_count <= line_count + LCW'(1);
          last_start <= next_pos;
        end else begin
          overflowed <= 1'b1;
        end
      end else if (lf_fold) begin
        last_start <= next_pos;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsil_pkg::ST_IDLE;
    end else begin
      unique case (state)
        lsil_pkg::ST_IDLE: begin
          if (s_xact && (cmd == lsil_pkg::CMD_LOCATE)) begin
            state <= lsil_pkg::ST_SEARCH;
          end
        end
        lsil_pkg::ST_SEARCH: begin
          if (done) begin
            state <= lsil_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= lsil_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // search registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (s_xact && (cmd == lsil_pkg::CMD_LOCATE)) begin
      q_off      <= in_off;
      q_bad      <= (in_off > text_length);
      lo         <= '0;
      // an offset past the text skips the search
      hi         <= (in_off > text_length) ? '0 : line_count;
      mid        <= mid_first;
      best_start <= '0;
    end else if ((state == lsil_pkg::ST_SEARCH) && searching) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
      if (le) begin
        best_start <= probe;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      line_number      <= q_bad ? '0 : AW'(lo - LCW'(1));
      column           <= q_bad ? '0 : (q_off - best_start);
      flags.bad_offset <= q_bad;
      flags.table_full <= overflowed;
    end
  end

  always_comb begin
    m_tdata                   = '0;
    m_tdata[AW-1:0]           = line_number;
    m_tdata[AW +: OFFSET_BITS] = column;
  end

  assign m_tuser = flags;

endmodule

// File: dv/line_start_index_and_locate_unit_test.sv
module line_start_index_and_locate_unit_test;

  localparam int LINES   = lsil_pkg::MAX_LINES_DEF;
  localparam int OB      = lsil_pkg::OFFSET_BITS_DEF;
  localparam int LINE_W  = $clog2(LINES);
  localparam int S_DW    = ((lsil_pkg::BYTE_W + OB + 7) / 8) * 8;
  localparam int M_DW    = ((LINE_W + OB + 7) / 8) * 8;
  localparam logic [OB-1:0] TEXT_MAX = '1;
  // Longest stretch with no transaction on either side before giving up.
  // The worst legit case is the long receiver hold (HOLD_CYCLES) plus a search.
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 24;   // outlasts the longest locate search

  // One command transaction as the sender sees it
  typedef struct packed {
    lsil_pkg::cmd_t cmd;
    logic [7:0]     ch;
    logic [OB-1:0]  offset;
  } text_cmd_t;

  // One locate answer
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [OB-1:0]     col;
    logic              bad;
    logic              full;
  } locate_ans_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [S_DW-1:0]            s_tdata  = '0;  // text_byte, query_offset
  logic [lsil_pkg::CMD_W-1:0] s_tuser  = lsil_pkg::CMD_NONE;  // command
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [M_DW-1:0]            m_tdata;   // line_number, column
  logic [1:0]                 m_tuser;   // bad_offset, table_full

  line_start_index_and_locate_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Line-start predictor: own copy of the table, text length and flags
  // ---------------------------------------------------------------------------
  logic [OB-1:0] start_tbl [LINES];
  int unsigned   start_cnt;
  logic [OB-1:0] text_len;
  bit            after_cr;
  bit            starts_dropped;

  locate_ans_t   locate_expect_q [$];
  int unsigned   mismatches = 0;

  function void clear_text();
    start_tbl[0]   = '0;
    start_cnt      = 1;
    text_len       = '0;
    after_cr       = 1'b0;
    starts_dropped = 1'b0;
  endfunction

  function void record_start(logic [OB-1:0] pos);
    if (start_cnt < LINES) begin
      start_tbl[start_cnt] = pos;
      start_cnt++;
    end else begin
      starts_dropped = 1'b1;
    end
  endfunction

  function void append_char(logic [7:0] ch);
    logic [OB-1:0] pos;
    pos = text_len;
    if (text_len == TEXT_MAX) return;   // text full: byte dropped, CR state kept
    text_len = pos + OB'(1);
    if (ch == lsil_pkg::CHAR_CR) begin
      record_start(pos + OB'(1));
      after_cr = 1'b1;
    end else if (ch == lsil_pkg::CHAR_LF) begin
      if (after_cr) begin
        // CR LF counts once: slide the CR's start past the LF, if it was kept
        if (start_tbl[start_cnt-1] == pos) start_tbl[start_cnt-1] = pos + OB'(1);
      end else begin
        record_start(pos + OB'(1));
      end
      after_cr = 1'b0;
    end else begin
      after_cr = 1'b0;
    end
  endfunction

  function locate_ans_t locate_line(logic [OB-1:0] off);
    locate_ans_t ans;
    int unsigned lo, hi, mid, idx;
    ans      = '0;
    ans.full = starts_dropped;
    if (off > text_len) begin
      ans.bad = 1'b1;
      return ans;
    end
    lo = 0;
    hi = start_cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (start_tbl[mid] <= off) lo = mid + 1;
      else hi = mid;
    end
    idx      = (lo > 0) ? lo - 1 : 0;
    ans.line = idx[LINE_W-1:0];
    ans.col  = off - start_tbl[idx];
    return ans;
  endfunction

  function void apply_command(text_cmd_t c);
    case (c.cmd)
      lsil_pkg::CMD_APPEND: append_char(c.ch);
      lsil_pkg::CMD_LOCATE: locate_expect_q.insert(locate_expect_q.size(), locate_line(c.offset));
      lsil_pkg::CMD_CLEAR:  clear_text();
      default: ;
    endcase
  endfunction

  function void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted command, checks every accepted result
  // ---------------------------------------------------------------------------
  locate_ans_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      clear_text();
    end else begin
      if (s_tvalid && s_tready)
        apply_command('{cmd: lsil_pkg::cmd_t'(s_tuser), ch: s_tdata[7:0],
                        offset: s_tdata[lsil_pkg::BYTE_W +: OB]});
      if (m_tvalid && m_tready) begin
        got.line = m_tdata[LINE_W-1:0];
        got.col  = m_tdata[LINE_W +: OB];
        got.bad  = m_tuser[0];
        got.full = m_tuser[1];
        if (locate_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result line %0d col %0d bad %b full %b",
                                    got.line, got.col, got.bad, got.full));
        end else begin
          want = locate_expect_q.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "expected line %0d col %0d bad %b full %b, got line %0d col %0d bad %b full %b",
              want.line, want.col, want.bad, want.full,
              got.line, got.col, got.bad, got.full));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: pops pending commands, offers them in bursts separated by gaps
  // ---------------------------------------------------------------------------
  text_cmd_t   pending_cmd_q [$];
  text_cmd_t   next_cmd;
  bit          sender_gaps = 1'b1;   // cleared for gap-free stretches
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_cmd_q.size() != 0) begin
        next_cmd = pending_cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DW-lsil_pkg::BYTE_W-OB){1'b0}}, next_cmd.offset, next_cmd.ch};
        s_tuser  <= next_cmd.cmd;
        if (burst_left != 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left   <= sender_gaps ? $urandom_range(0, 5) : 0;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: cycles through ready patterns; a toggle of hold_req asks for
  // one long hold-off that this process counts down itself
  // ---------------------------------------------------------------------------
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int unsigned hold_left = 0;
  logic [11:0] rx_cycle = '0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      rx_cycle  <= '0;
    end else begin
      rx_cycle <= rx_cycle + 12'd1;
      if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        case (rx_cycle[11:10])
          2'd0: m_tready <= 1'b1;
          2'd1: m_tready <= ($urandom_range(0, 1) == 0);
          2'd2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_cycle[2:0] != 3'd0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no transaction on either side for too long ends the run
  // ---------------------------------------------------------------------------
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int unsigned doc_len = 0;   // length of the current text as the sender sees it

  // Queue one command; the wrappers below give unused fields random bits. Throttled so the
  // pending queue stays short.
  task automatic send(lsil_pkg::cmd_t c, logic [7:0] ch, logic [OB-1:0] off);
    text_cmd_t item;
    while (pending_cmd_q.size() >= 16) @(negedge clk);
    item = '{cmd: c, ch: ch, offset: off};
    pending_cmd_q.insert(pending_cmd_q.size(), item);
    if (c == lsil_pkg::CMD_APPEND && doc_len < TEXT_MAX) doc_len++;
    if (c == lsil_pkg::CMD_CLEAR) doc_len = 0;
  endtask

  task automatic send_append(logic [7:0] ch);
    send(lsil_pkg::CMD_APPEND, ch, OB'($urandom));
  endtask

  task automatic send_locate(logic [OB-1:0] off);
    send(lsil_pkg::CMD_LOCATE, 8'($urandom), off);
  endtask

  // Mostly inside the text, some just past its end, some anywhere
  function automatic logic [OB-1:0] pick_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return OB'($urandom_range(0, doc_len));
    if (r < 90) return OB'(doc_len + $urandom_range(1, 16));
    return OB'($urandom);
  endfunction

  // Text with terminators mixed in at term_pct percent; after each byte or CR LF
  // pair a locate follows with chance q_frac/1024
  task automatic write_text(int unsigned n, int unsigned term_pct, int unsigned q_frac);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < term_pct / 3) begin
        send_append(lsil_pkg::CHAR_CR);
      end else if (r < 2 * term_pct / 3) begin
        send_append(lsil_pkg::CHAR_LF);
      end else if (r < term_pct) begin
        send_append(lsil_pkg::CHAR_CR);
        send_append(lsil_pkg::CHAR_LF);
      end else begin
        send_append(8'($urandom));
      end
      if ($urandom_range(0, 1023) < q_frac) send_locate(pick_offset());
    end
  endtask

  // Sender stops until everything offered is taken and answered
  task automatic wait_drained();
    while (pending_cmd_q.size() != 0 || s_tvalid || locate_expect_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty text, each terminator form, boundaries of the offset
    send_locate('0);                 // offset equal to length of empty text
    send_locate(OB'(1));             // just past the end
    send_append("a");
    send_append(lsil_pkg::CHAR_CR);
    send_append(lsil_pkg::CHAR_LF);  // CR LF counts once
    send_append("b");
    send_append(lsil_pkg::CHAR_LF);  // lone LF
    send_append(lsil_pkg::CHAR_CR);
    send_append(lsil_pkg::CHAR_CR);  // CR CR: two lines
    send_append(8'hFF);
    send_append(8'h00);
    send_locate(OB'(2));
    send_locate(OB'(3));
    send_locate('0);
    send_locate(OB'(doc_len));       // equal to text length: last line
    send_locate(OB'(doc_len + 1));
    send_locate(TEXT_MAX);
    send(lsil_pkg::CMD_NONE, 8'hFF, TEXT_MAX); // unused command: ignored
    send_locate(OB'(5));
    send(lsil_pkg::CMD_CLEAR, 8'($urandom), OB'($urandom));
    send_locate('0);
    send_locate(OB'(1));
    wait_drained();

    // Random texts of random size, with and without sender gaps
    for (int d = 0; d < 24; d++) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (d == 6) hold_req = ~hold_req;    // long receiver hold while queries pile up
      if (d == 12) wait_drained();
      send(lsil_pkg::CMD_CLEAR, 8'($urandom), OB'($urandom));
      write_text($urandom_range(4, 42), 30, 256);
      if ($urandom_range(0, 99) < 20) send(lsil_pkg::CMD_NONE, 8'($urandom), OB'($urandom));
      repeat ($urandom_range(1, 4)) send_locate(pick_offset());
    end
    send_locate(OB'(doc_len));

    // Tail: everything taken and answered, then a wait of TAIL_CYCLES for stray results
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (locate_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", locate_expect_q.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
